### rtl/core/lfra_pkg.sv
// Shared types and constants for the lowest free room allocator.
// No dependencies; imported by lfra_cell and the top level.
package lfra_pkg;

  localparam int OUT_W          = 9;
  localparam int ROOM_COUNT_DEF = 256;
  localparam int TIME_BITS_DEF  = 32;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] room;
    logic [OUT_W-1:0] cnt;
  } lfra_tag_t;

endpackage

### rtl/core/lfra_cell.sv
// One room cell: holds the room's end time and open flag, checks the passing
// request word against them and registers the word for the next cell.
// Depends on lfra_pkg.
module lfra_cell
  import lfra_pkg::*;
#(
  parameter int               TIME_BITS = TIME_BITS_DEF,
  parameter logic [OUT_W-1:0] ROOM_ID   = OUT_W'(1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  lfra_tag_t            in_tag,
  input  logic [TIME_BITS-1:0] in_arr,
  input  logic [TIME_BITS-1:0] in_dep,
  output logic                 out_vld,
  output lfra_tag_t            out_tag,
  output logic [TIME_BITS-1:0] out_arr,
  output logic [TIME_BITS-1:0] out_dep
);

  logic                 open_r;
  logic [TIME_BITS-1:0] end_r;
  logic                 vld_r;
  lfra_tag_t            tag_r;
  lfra_tag_t            tag_nxt;
  logic [TIME_BITS-1:0] arr_r;
  logic [TIME_BITS-1:0] dep_r;
  logic                 free;
  logic                 grant;

  assign free  = !open_r || (end_r < in_arr);
  assign grant = in_vld && !in_tag.done && free;

  always_comb begin
    tag_nxt      = in_tag;
    tag_nxt.done = in_tag.done | grant;
    tag_nxt.room = grant ? ROOM_ID : in_tag.room;
    tag_nxt.cnt  = in_tag.cnt + OUT_W'(open_r | grant);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      vld_r  <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
      if (grant) begin
        open_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r <= tag_nxt;
      arr_r <= in_arr;
      dep_r <= in_dep;
      if (grant) begin
        end_r <= in_dep;
      end
    end
  end

  assign out_vld = vld_r;
  assign out_tag = tag_r;
  assign out_arr = arr_r;
  assign out_dep = dep_r;

  a_open_on_first_use : assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_vld && !in_tag.done && !open_r |=> open_r)
    else $error("unopened cell passed a pending request without opening");

  a_open_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    open_r |=> open_r)
    else $error("open room closed");

  a_done_holds_room : assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_vld && in_tag.done |=> tag_r.done && tag_r.room == $past(in_tag.room))
    else $error("granted request changed its room");

endmodule

### rtl/core/lowest_free_room_allocator_unit.sv
// Lowest free room allocator: a row of room cells that a request word walks
// through, one cell per cycle while the row is not stalled. Depends on lfra_pkg and lfra_cell.
//
// Usage:
//   Input channel in_valid/in_stall carries arrival and departure times, in
//   order of arrival. Output channel out_valid/out_stall carries the granted
//   room (from 1, 0 when full), the rooms opened so far and all_full.
//   Each cell k holds room k+1's end time. A request grants the first cell that
//   is unopened or whose end time is below the arrival; later cells only
//   count their open rooms into rooms_opened.
//   Each cell registers the word; the result word is the last cell's register.
//   Throughput: one word per cycle while no result is held stalled; each request
//   trails the one before it through the row, so each cell sees requests in order.
//   Reset: all rooms closed, pipeline empty, no result pending.
//   Stall: while a result word is held stalled the whole row holds and
//   in_stall is raised; nothing is dropped.
module lowest_free_room_allocator_unit
  import lfra_pkg::*;
#(
  parameter int ROOM_COUNT = ROOM_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_BITS-1:0] in_arrival_time,
  input  logic [TIME_BITS-1:0] in_departure_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_granted_room,
  output logic [OUT_W-1:0]     out_rooms_opened,
  output logic                 out_all_full
);

  logic                 adv;
  logic                 vld [ROOM_COUNT+1];
  lfra_tag_t            tag [ROOM_COUNT+1];
  logic [TIME_BITS-1:0] arr [ROOM_COUNT+1];
  logic [TIME_BITS-1:0] dep [ROOM_COUNT+1];

  assign adv      = !(vld[ROOM_COUNT] && out_stall);
  assign in_stall = !adv;

  assign vld[0] = in_valid;
  assign tag[0] = '0;
  assign arr[0] = in_arrival_time;
  assign dep[0] = in_departure_time;

  for (genvar k = 0; k < ROOM_COUNT; k++) begin : g_cell
    lfra_cell #(
      .TIME_BITS (TIME_BITS),
      .ROOM_ID   (OUT_W'(k + 1))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (vld[k]),
      .in_tag  (tag[k]),
      .in_arr  (arr[k]),
      .in_dep  (dep[k]),
      .out_vld (vld[k+1]),
      .out_tag (tag[k+1]),
      .out_arr (arr[k+1]),
      .out_dep (dep[k+1])
    );
  end

  assign out_valid        = vld[ROOM_COUNT];
  assign out_granted_room = tag[ROOM_COUNT].done ? tag[ROOM_COUNT].room : '0;
  assign out_rooms_opened = tag[ROOM_COUNT].cnt;
  assign out_all_full     = !tag[ROOM_COUNT].done;

  a_full_no_room : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_full |-> out_granted_room == '0)
    else $error("full result carries a room");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_all_full |-> out_rooms_opened == OUT_W'(ROOM_COUNT))
    else $error("full flagged before every room opened");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule
